@@ rtl/pad_source_address_generator_top_defines.svh @@
// Assertion macros shared by the RTL
`ifndef PAD_SOURCE_ADDRESS_GENERATOR_TOP_DEFINES_SVH
`define PAD_SOURCE_ADDRESS_GENERATOR_TOP_DEFINES_SVH

// Same-cycle implication
`define PSAG_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define PSAG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/psag_pkg.sv @@
`default_nettype none
package psag_pkg;

    localparam int RANK_DEF       = 4;
    localparam int DIM_BITS_DEF   = 16;
    localparam int INDEX_BITS_DEF = 32;

    localparam int REG_BITS     = 64;
    localparam int CFG_IDX_BITS = 2;
    localparam int SRC_IDX_BITS = 32;

    localparam logic [CFG_IDX_BITS-1:0] CFG_PAD_MODE  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IN_SHAPE  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OUT_SHAPE = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PAD_BEGIN = 2'd3;

    localparam logic [63:0] SHAPE_RESET = 64'd281479271743489;

    typedef enum logic [1:0] {
        MODE_CONST   = 2'd0,
        MODE_REFLECT = 2'd1,
        MODE_EDGE    = 2'd2,
        MODE_WRAP    = 2'd3
    } t_pad_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIM,
        S_DIV,
        S_FIX,
        S_MUL,
        S_ADD,
        S_OUT
    } t_back_state;

    // Per-dimension field of a packed register; fields past the register read as dflt
    function automatic logic [63:0] field_of(input logic [63:0] reg_v, input int d,
                                             input int dim_bits, input logic [63:0] dflt);
        int          sh;
        logic [63:0] mask;
        sh   = d * dim_bits;
        mask = (64'd1 << dim_bits) - 64'd1;
        if (sh >= 64) begin
            return dflt;
        end
        return (reg_v >> sh) & mask;
    endfunction

endpackage
`default_nettype wire

@@ rtl/psag_fifo.sv @@
`default_nettype none
module psag_fifo import psag_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp, n_wp, n_rp;
    logic [CW-1:0]    r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_comb begin
        n_wp = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
        n_rp = (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= n_wp;
            end
            if (i_pop) begin
                r_rp <= n_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end
endmodule
`default_nettype wire

@@ rtl/psag_front.sv @@
`default_nettype none
module psag_front import psag_pkg::*; #(
    parameter int RANK     = RANK_DEF,
    parameter int DIM_BITS = DIM_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [REG_BITS-1:0]           i_out_shape,
    input  wire logic [REG_BITS-1:0]           i_pad_begin,
    input  wire logic                          i_valid,
    input  wire logic                          i_restart,
    input  wire logic                          i_room,
    output logic                               o_ready,
    output logic                               o_push,
    output logic [RANK*(DIM_BITS+2):0]         o_entry
);
    localparam int CW = DIM_BITS + 2;

    logic [DIM_BITS-1:0] r_coord [RANK];
    logic [DIM_BITS-1:0] n_coord [RANK];
    logic [DIM_BITS-1:0] w_base  [RANK];
    logic [DIM_BITS-1:0] w_olen  [RANK];
    logic [DIM_BITS-1:0] w_pad   [RANK];
    logic                w_last;
    logic                w_carry;

    assign o_ready = i_room;
    assign o_push  = i_valid && i_room;

    always_comb begin
        w_last  = 1'b1;
        w_carry = 1'b1;
        for (int d = 0; d < RANK; d++) begin
            w_olen[d] = DIM_BITS'(field_of(i_out_shape, d, DIM_BITS, 64'd1));
            if (w_olen[d] == '0) begin
                w_olen[d] = DIM_BITS'(1);
            end
            w_pad[d]  = DIM_BITS'(field_of(i_pad_begin, d, DIM_BITS, 64'd0));
            w_base[d] = i_restart ? '0 : r_coord[d];
            if (w_base[d] < w_olen[d] - DIM_BITS'(1)) begin
                w_last = 1'b0;
            end
            o_entry[d*CW +: CW] = CW'(w_base[d]) - CW'($signed(w_pad[d]));
        end
        o_entry[RANK*CW] = w_last;
        // innermost dimension counts fastest; a stale coordinate wraps to zero
        for (int d = 0; d < RANK; d++) begin
            n_coord[d] = w_base[d];
            if (w_carry) begin
                if ({1'b0, w_base[d]} + (DIM_BITS+1)'(1) >= {1'b0, w_olen[d]}) begin
                    n_coord[d] = '0;
                end else begin
                    n_coord[d] = w_base[d] + DIM_BITS'(1);
                    w_carry    = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < RANK; d++) begin
                r_coord[d] <= '0;
            end
        end else if (o_push) begin
            r_coord <= n_coord;
        end
    end
endmodule
`default_nettype wire

@@ rtl/psag_back.sv @@
`default_nettype none
module psag_back import psag_pkg::*; #(
    parameter int RANK       = RANK_DEF,
    parameter int DIM_BITS   = DIM_BITS_DEF,
    parameter int INDEX_BITS = INDEX_BITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic [1:0]                i_pad_mode,
    input  wire logic [REG_BITS-1:0]       i_in_shape,
    input  wire logic                      i_empty,
    input  wire logic [RANK*(DIM_BITS+2):0] i_entry,
    output logic                           o_pop,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic [SRC_IDX_BITS-1:0]        o_src_index,
    output logic                           o_use_constant,
    output logic                           o_index_overflow,
    output logic                           o_last
);
    localparam int CW  = DIM_BITS + 2;
    localparam int MW  = DIM_BITS + 1;
    localparam int OB  = (INDEX_BITS < SRC_IDX_BITS) ? INDEX_BITS : SRC_IDX_BITS;
    localparam int PW  = OB + DIM_BITS;
    localparam int DW  = (RANK > 1) ? $clog2(RANK) : 1;
    localparam int NW  = $clog2(MW + 1);

    t_back_state r_state, n_state;

    logic [RANK*CW:0]     r_entry;
    logic [DW-1:0]        r_dim;
    logic [DIM_BITS-1:0]  r_len;
    logic [MW-1:0]        r_m;
    logic [MW-1:0]        r_rem;
    logic [MW-1:0]        r_num;
    logic [NW-1:0]        r_cnt;
    logic                 r_neg;
    logic [DIM_BITS-1:0]  r_val;
    logic [OB-1:0]        r_idx;
    logic [PW-1:0]        r_prod;
    logic                 r_uc;
    logic                 r_ovf;

    logic [DIM_BITS-1:0]  w_len;
    logic signed [CW-1:0] w_c;
    logic                 w_in_range;
    logic                 w_const_dim;
    logic                 w_direct;
    logic                 w_div;
    logic [DIM_BITS-1:0]  w_direct_val;
    logic [MW-1:0]        w_m;
    logic [MW-1:0]        w_abs;
    logic [MW:0]          w_rem_sh;
    logic [MW-1:0]        w_rem_nx;
    logic [MW-1:0]        w_k0;
    logic [MW-1:0]        w_k1;
    logic [PW-1:0]        w_prod;
    logic [PW:0]          w_sum;
    logic                 w_add_ovf;
    logic                 w_last_dim;
    t_pad_mode            w_mode;

    assign w_mode     = t_pad_mode'(i_pad_mode);
    assign w_last_dim = (r_dim == '0);

    always_comb begin
        w_len      = DIM_BITS'(field_of(i_in_shape, int'(r_dim), DIM_BITS, 64'd1));
        w_c        = $signed(r_entry[r_dim*CW +: CW]);
        w_in_range = !w_c[CW-1] && (w_c < $signed({2'b00, w_len}));
        w_abs      = w_c[CW-1] ? MW'(-w_c) : MW'(w_c);
        w_m        = (w_mode == MODE_REFLECT) ? ({1'b0, w_len} << 1) - MW'(2)
                                              : {1'b0, w_len};
        w_const_dim  = 1'b0;
        w_direct     = 1'b0;
        w_div        = 1'b0;
        w_direct_val = w_c[DIM_BITS-1:0];
        if (w_len == '0) begin
            w_const_dim = 1'b1;
        end else if (w_in_range) begin
            w_direct = 1'b1;
        end else begin
            unique case (w_mode)
                MODE_CONST: w_const_dim = 1'b1;
                MODE_EDGE: begin
                    w_direct     = 1'b1;
                    w_direct_val = w_c[CW-1] ? '0 : w_len - DIM_BITS'(1);
                end
                MODE_REFLECT: begin
                    if (w_len == DIM_BITS'(1)) begin
                        w_direct     = 1'b1;
                        w_direct_val = '0;
                    end else begin
                        w_div = 1'b1;
                    end
                end
                MODE_WRAP: w_div = 1'b1;
                default: w_const_dim = 1'b1;
            endcase
        end
    end

    // one restoring-division bit per cycle
    always_comb begin
        w_rem_sh = {r_rem, r_num[MW-1]};
        w_rem_nx = (w_rem_sh >= {1'b0, r_m}) ? MW'(w_rem_sh - {1'b0, r_m}) : MW'(w_rem_sh);
    end

    always_comb begin
        w_k0 = (r_neg && r_rem != '0) ? r_m - r_rem : r_rem;
        w_k1 = (w_mode == MODE_REFLECT && w_k0 >= {1'b0, r_len}) ? r_m - w_k0 : w_k0;
    end

    always_comb begin
        w_prod    = PW'(r_idx) * PW'(r_len);
        w_sum     = {1'b0, r_prod} + (PW+1)'(r_val);
        w_add_ovf = (r_prod > PW'({OB{1'b1}})) || (w_sum > (PW+1)'({OB{1'b1}}));
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (!i_empty) n_state = S_DIM;
            S_DIM: begin
                if (w_div) begin
                    n_state = S_DIV;
                end else if (w_direct) begin
                    n_state = S_MUL;
                end else begin
                    n_state = w_last_dim ? S_OUT : S_DIM;
                end
            end
            S_DIV: if (r_cnt == NW'(1)) n_state = S_FIX;
            S_FIX: n_state = S_MUL;
            S_MUL: begin
                if (r_ovf) begin
                    n_state = w_last_dim ? S_OUT : S_DIM;
                end else begin
                    n_state = S_ADD;
                end
            end
            S_ADD: n_state = w_last_dim ? S_OUT : S_DIM;
            S_OUT: if (i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_pop            = (r_state == S_IDLE) && !i_empty;
        o_valid          = (r_state == S_OUT);
        o_use_constant   = r_uc;
        o_index_overflow = r_ovf && !r_uc;
        o_src_index      = (r_uc || r_ovf) ? '0 : SRC_IDX_BITS'(r_idx);
        o_last           = r_entry[RANK*CW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    r_entry <= i_entry;
                    r_dim   <= DW'(RANK - 1);
                    r_idx   <= '0;
                    r_uc    <= 1'b0;
                    r_ovf   <= 1'b0;
                end
            end
            S_DIM: begin
                r_len <= w_len;
                r_m   <= w_m;
                r_neg <= w_c[CW-1];
                r_num <= w_abs;
                r_rem <= '0;
                r_cnt <= NW'(MW);
                r_val <= w_direct_val;
                if (w_const_dim) begin
                    r_uc <= 1'b1;
                    if (!w_last_dim) begin
                        r_dim <= r_dim - DW'(1);
                    end
                end
            end
            S_DIV: begin
                r_rem <= w_rem_nx;
                r_num <= r_num << 1;
                r_cnt <= r_cnt - NW'(1);
            end
            S_FIX: r_val <= DIM_BITS'(w_k1);
            S_MUL: begin
                r_prod <= w_prod;
                if (r_ovf && !w_last_dim) begin
                    r_dim <= r_dim - DW'(1);
                end
            end
            S_ADD: begin
                if (w_add_ovf) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_idx <= OB'(w_sum);
                end
                if (!w_last_dim) begin
                    r_dim <= r_dim - DW'(1);
                end
            end
            S_OUT: ;
            default: ;
        endcase
    end
endmodule
`default_nettype wire

@@ rtl/pad_source_address_generator_top.sv @@
// Channel  Handshake                Payload
// config   i_cfg_we                 i_cfg_index, i_cfg_data
// input    i_valid / o_ready        i_restart
// output   o_valid / i_ready        o_src_index, o_use_constant, o_index_overflow, o_last
//
// The front steps the output coordinates once per accepted beat and queues two beats.
// The back walks dimensions outermost first: S_DIM, S_MUL and S_ADD for in-range or edge,
// S_DIM alone for constant, S_DIM and S_MUL after overflow; reflect or wrap inserts S_DIV
// (the modulo unit) and S_FIX before S_MUL. The back pops a beat only after the last leaves S_OUT.
// Reset is synchronous, active low; registers return to their default shapes.
// A stalled output holds the back; the front keeps accepting until the queue fills.
`default_nettype none
`include "pad_source_address_generator_top_defines.svh"
module pad_source_address_generator_top import psag_pkg::*; #(
    parameter int RANK       = RANK_DEF,
    parameter int DIM_BITS   = DIM_BITS_DEF,
    parameter int INDEX_BITS = INDEX_BITS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [REG_BITS-1:0]     i_cfg_data,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic                    i_restart,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic [SRC_IDX_BITS-1:0]      o_src_index,
    output logic                         o_use_constant,
    output logic                         o_index_overflow,
    output logic                         o_last
);
    localparam int EW = RANK * (DIM_BITS + 2) + 1;

    logic [1:0]          r_pad_mode;
    logic [REG_BITS-1:0] r_in_shape;
    logic [REG_BITS-1:0] r_out_shape;
    logic [REG_BITS-1:0] r_pad_begin;

    logic          w_push, w_pop, w_full, w_empty;
    logic [EW-1:0] w_front_entry, w_back_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad_mode  <= MODE_CONST;
            r_in_shape  <= SHAPE_RESET;
            r_out_shape <= SHAPE_RESET;
            r_pad_begin <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PAD_MODE:  r_pad_mode  <= i_cfg_data[1:0];
                CFG_IN_SHAPE:  r_in_shape  <= i_cfg_data;
                CFG_OUT_SHAPE: r_out_shape <= i_cfg_data;
                CFG_PAD_BEGIN: r_pad_begin <= i_cfg_data;
                default: ;
            endcase
        end
    end

    psag_front #(.RANK(RANK), .DIM_BITS(DIM_BITS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_out_shape (r_out_shape),
        .i_pad_begin (r_pad_begin),
        .i_valid     (i_valid),
        .i_restart   (i_restart),
        .i_room      (!w_full),
        .o_ready     (o_ready),
        .o_push      (w_push),
        .o_entry     (w_front_entry)
    );

    psag_fifo #(.WIDTH(EW), .DEPTH(2)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front_entry),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_back_entry),
        .o_empty (w_empty)
    );

    psag_back #(.RANK(RANK), .DIM_BITS(DIM_BITS), .INDEX_BITS(INDEX_BITS)) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_pad_mode       (r_pad_mode),
        .i_in_shape       (r_in_shape),
        .i_empty          (w_empty),
        .i_entry          (w_back_entry),
        .o_pop            (w_pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_src_index      (o_src_index),
        .o_use_constant   (o_use_constant),
        .o_index_overflow (o_index_overflow),
        .o_last           (o_last)
    );

    `PSAG_ASSERT_NOW(a_const_clean, i_clk, i_rst_n, o_valid && o_use_constant, o_src_index == '0 && !o_index_overflow, "constant beat carries an index")
    `PSAG_ASSERT_NOW(a_ovf_zero, i_clk, i_rst_n, o_valid && o_index_overflow, o_src_index == '0, "overflow beat carries an index")
    `PSAG_ASSERT_NOW(a_no_push_full, i_clk, i_rst_n, w_full, !w_push, "push into full queue")
    `PSAG_ASSERT_NEXT(a_pop_fills, i_clk, i_rst_n, w_pop, !o_valid, "pop while result pending")
endmodule
`default_nettype wire

@@ sim/pad_addr_checker.sv @@
`timescale 1ns / 1ps
module pad_addr_checker import psag_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [REG_BITS-1:0]     i_cfg_data,
    input  wire logic                    i_valid,
    input  wire logic                    i_ready_in,
    input  wire logic                    i_restart,
    input  wire logic                    i_out_valid,
    input  wire logic                    i_out_ready,
    input  wire logic [SRC_IDX_BITS-1:0] i_src_index,
    input  wire logic                    i_use_constant,
    input  wire logic                    i_index_overflow,
    input  wire logic                    i_last,
    output int                           o_fail_count,
    output int                           o_pending
);
    localparam int NDIM = 4;
    localparam longint unsigned IDX_MAX = 64'hFFFF_FFFF;

    typedef struct packed {
        logic [31:0] src_index;
        logic        use_constant;
        logic        index_overflow;
        logic        last;
    } t_addr_beat;

    t_pad_mode   mode_q;
    logic [63:0] in_shape_q;
    logic [63:0] out_shape_q;
    logic [63:0] pad_begin_q;
    logic [15:0] coord_q [NDIM];
    t_addr_beat  addr_queue [$];
    int          fails;

    assign o_fail_count = fails;
    assign o_pending    = addr_queue.size();

    function automatic longint unsigned out_len(input int d);
        logic [15:0] v;
        v = out_shape_q[d*16 +: 16];
        return (v == 16'd0) ? 64'd1 : 64'(v);
    endfunction

    // Address of the current output element; advance the coordinates after.
    function automatic t_addr_beat next_address(input logic restart);
        t_addr_beat        r;
        longint unsigned   inlen;
        longint unsigned   idx;
        longint            len;
        longint            c;
        longint            m;
        longint            k;
        logic signed [15:0] p;
        logic              uc;
        logic              ovf;
        logic              lst;
        logic              carry;
        idx = 0;
        uc  = 1'b0;
        ovf = 1'b0;
        lst = 1'b1;
        if (restart) begin
            for (int d = 0; d < NDIM; d++) coord_q[d] = '0;
        end
        for (int d = NDIM - 1; d >= 0; d--) begin
            inlen = 64'(in_shape_q[d*16 +: 16]);
            len   = longint'(inlen);
            p     = pad_begin_q[d*16 +: 16];
            c     = longint'(coord_q[d]) - longint'(p);
            if (inlen == 0) begin
                uc = 1'b1;
                continue;
            end
            if (c < 0 || c >= len) begin
                case (mode_q)
                    MODE_CONST: begin
                        uc = 1'b1;
                        continue;
                    end
                    MODE_REFLECT: begin
                        if (len == 1) begin
                            c = 0;
                        end else begin
                            m = 2 * len - 2;
                            k = c % m;
                            if (k < 0) k += m;
                            if (k >= len) k = m - k;
                            c = k;
                        end
                    end
                    MODE_EDGE: c = (c < 0) ? 0 : len - 1;
                    default: begin
                        c = c % len;
                        if (c < 0) c += len;
                    end
                endcase
            end
            if (!ovf) begin
                if (idx > IDX_MAX / inlen) begin
                    ovf = 1'b1;
                end else begin
                    idx = idx * inlen;
                    if (unsigned'(c) > IDX_MAX - idx) ovf = 1'b1;
                    else idx = idx + unsigned'(c);
                end
            end
        end
        if (uc) begin
            idx = 0;
            ovf = 1'b0;
        end
        if (ovf) idx = 0;
        for (int d = 0; d < NDIM; d++) begin
            if (64'(coord_q[d]) < out_len(d) - 1) lst = 1'b0;
        end
        // Stale coordinates past their length wrap like the end of the dimension
        carry = 1'b1;
        for (int d = 0; d < NDIM && carry; d++) begin
            if (64'(coord_q[d]) + 1 >= out_len(d)) begin
                coord_q[d] = '0;
            end else begin
                coord_q[d] = coord_q[d] + 16'd1;
                carry = 1'b0;
            end
        end
        r.src_index      = idx[31:0];
        r.use_constant   = uc;
        r.index_overflow = ovf;
        r.last           = lst;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_addr_beat exp_beat;
        t_addr_beat got_beat;
        if (!i_rst_n) begin
            mode_q      <= MODE_CONST;
            in_shape_q  <= SHAPE_RESET;
            out_shape_q <= SHAPE_RESET;
            pad_begin_q <= '0;
            for (int d = 0; d < NDIM; d++) coord_q[d] = '0;
            addr_queue.delete();
            fails = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PAD_MODE:  mode_q      <= t_pad_mode'(i_cfg_data[1:0]);
                    CFG_IN_SHAPE:  in_shape_q  <= i_cfg_data;
                    CFG_OUT_SHAPE: out_shape_q <= i_cfg_data;
                    default:       pad_begin_q <= i_cfg_data;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                got_beat = '{i_src_index, i_use_constant, i_index_overflow, i_last};
                if (addr_queue.size() == 0) begin
                    fails++;
                    if (fails <= 10) $display("unexpected output beat %p", got_beat);
                end else begin
                    exp_beat = addr_queue.pop_front();
                    if (got_beat !== exp_beat) begin
                        fails++;
                        if (fails <= 10)
                            $display("mismatch: expected %p got %p", exp_beat, got_beat);
                    end
                end
            end
            if (i_valid && i_ready_in) addr_queue.push_back(next_address(i_restart));
        end
    end
endmodule

@@ sim/pad_source_address_generator_top_tb.sv @@
`timescale 1ns / 1ps
module pad_source_address_generator_top_tb import psag_pkg::*;;
    localparam int STALL_LIMIT = 4000;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_index = CFG_PAD_MODE;
    logic [REG_BITS-1:0]     i_cfg_data = '0;
    logic                    i_valid = 1'b0;
    logic                    i_restart = 1'b0;
    logic                    i_ready = 1'b0;
    logic                    o_ready;
    logic                    o_valid;
    logic [SRC_IDX_BITS-1:0] o_src_index;
    logic                    o_use_constant;
    logic                    o_index_overflow;
    logic                    o_last;
    int                      fail_count;
    int                      pending;
    int                      tx_idle_pct = 0;
    int                      rx_idle_pct = 0;
    int                      rx_hold_req = 0;
    int                      quiet_cycles = 0;

    pad_source_address_generator_top i_dut (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_valid, .o_ready, .i_restart,
        .o_valid, .i_ready, .o_src_index, .o_use_constant, .o_index_overflow, .o_last
    );

    pad_addr_checker i_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_valid, .i_ready_in(o_ready), .i_restart,
        .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_src_index(o_src_index), .i_use_constant(o_use_constant),
        .i_index_overflow(o_index_overflow), .i_last(o_last),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: random stalls, plus a long hold-off when asked
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req > 0) begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready = 1'b0;
            end else begin
                i_ready = ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [63:0] data);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic load_shape(input t_pad_mode mode, input logic [63:0] in_shape,
                              input logic [63:0] out_shape, input logic [63:0] pads);
        write_reg(CFG_PAD_MODE, 64'(mode));
        write_reg(CFG_IN_SHAPE, in_shape);
        write_reg(CFG_OUT_SHAPE, out_shape);
        write_reg(CFG_PAD_BEGIN, pads);
    endtask

    // Offer one beat; called and returns at a falling edge
    task automatic send_beat(input logic restart);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_valid   = 1'b1;
        i_restart = restart;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    function automatic logic [63:0] rand_len_pack();
        logic [63:0] v;
        for (int d = 0; d < 4; d++) begin
            case ($urandom_range(0, 9))
                0:       v[d*16 +: 16] = 16'hFFFF;
                1:       v[d*16 +: 16] = 16'($urandom);
                default: v[d*16 +: 16] = 16'($urandom_range(0, 5));
            endcase
        end
        return v;
    endfunction

    function automatic logic [63:0] rand_pad_pack();
        logic [63:0] v;
        for (int d = 0; d < 4; d++) begin
            case ($urandom_range(0, 9))
                0:       v[d*16 +: 16] = 16'($urandom);
                1:       v[d*16 +: 16] = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
                default: v[d*16 +: 16] = 16'($urandom_range(0, 8) - 4);
            endcase
        end
        return v;
    endfunction

    function automatic logic [63:0] rand_out_pack();
        logic [63:0] v;
        for (int d = 0; d < 4; d++) v[d*16 +: 16] = 16'($urandom_range(0, 6));
        return v;
    endfunction

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: defaults, each mode on a small padded tensor, extremes
        send_beat(1'b0);
        send_beat(1'b1);
        drain();
        load_shape(MODE_CONST, 64'h0001_0001_0002_0003, 64'h0001_0001_0004_0005,
                   64'h0000_0000_0001_0001);
        repeat (6) send_beat(1'b0);
        drain();
        load_shape(MODE_REFLECT, 64'h0001_0001_0001_0003, 64'h0001_0001_0001_0009,
                   64'h0000_0000_0000_FFFD);
        repeat (5) send_beat(1'b0);
        drain();
        write_reg(CFG_PAD_MODE, 64'(MODE_EDGE));
        write_reg(CFG_PAD_BEGIN, 64'h7FFF_8000_7FFF_8000);
        repeat (3) send_beat(1'b1);
        drain();
        load_shape(MODE_WRAP, 64'h0000_0001_0001_0003, 64'h0000_0000_0001_0004,
                   64'h0000_0000_0000_0002);
        repeat (3) send_beat(1'b0);
        drain();
        // Huge source with large pads overflows the index width; shrink out shape
        load_shape(MODE_WRAP, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0002_0000_0000_0000,
                   64'h8000_7FFF_8000_7FFF);
        repeat (3) send_beat(1'b0);
        drain();

        for (int ph = 0; ph < 40; ph++) begin
            if (ph == 0) begin
                tx_idle_pct = 7;
                rx_idle_pct = 63;
            end else if (ph == 13) begin
                tx_idle_pct = 63;
                rx_idle_pct = 7;
            end else if (ph == 26) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            load_shape(t_pad_mode'($urandom_range(0, 3)), rand_len_pack(), rand_out_pack(),
                       rand_pad_pack());
            if (ph == 28) rx_hold_req = 400;
            for (int n = 0; n < 20; n++) begin
                if (ph == 30 && n == 10) drain();
                send_beat($urandom_range(0, 9) == 0);
            end
            drain();
        end

        repeat (100) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
